// ----- rtl/core/lru_address_lease_table_assert.svh -----
// Assertion macros for the lease table checker.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef LRU_ADDRESS_LEASE_TABLE_ASSERT_SVH
`define LRU_ADDRESS_LEASE_TABLE_ASSERT_SVH

// Overlapping implication: the consequent starts at the edge of the antecedent.
`define LALT_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Non-overlapping implication: the consequent starts at the edge after the antecedent.
`define LALT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/lalt_pkg.sv -----
// Shared types and constants for the LRU address lease table.
// Used by lalt_store, lalt_scan, the top level and the testbench; depends on nothing.
package lalt_pkg;

    localparam int ID_W          = 64;
    localparam int ADDR_W        = 8;
    localparam int DEF_ENTRIES   = 10;
    localparam int DEF_STAMP_W   = 32;
    localparam logic [ADDR_W-1:0] BASE_RESET = 8'd2;

    // Control from the sequencer to the lease memory.
    typedef struct packed {
        logic rd_en;    // read the entry at the read address
        logic wr_en;    // write id and stamp at the write address
        logic wr_live;  // written id is nonzero, so the entry is occupied
    } mem_ctl_t;

endpackage

// ----- rtl/core/lalt_store.sv -----
// Lease memory: one synchronous RAM holding id and stamp per entry, plus
// per-entry occupied flags cleared at reset. Depends on lalt_pkg.
module lalt_store #(
    parameter int TABLE_ENTRIES = lalt_pkg::DEF_ENTRIES,
    parameter int STAMP_WIDTH   = lalt_pkg::DEF_STAMP_W,
    parameter int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  lalt_pkg::mem_ctl_t      ctl,
    input  logic [IDX_W-1:0]        rd_addr,
    input  logic [IDX_W-1:0]        wr_addr,
    input  logic [lalt_pkg::ID_W-1:0] wr_id,
    input  logic [STAMP_WIDTH-1:0]  wr_stamp,
    output logic [lalt_pkg::ID_W-1:0] rd_id,
    output logic [STAMP_WIDTH-1:0]  rd_stamp,
    output logic                    rd_empty
);

    localparam int MEM_W = lalt_pkg::ID_W + STAMP_WIDTH;

    logic [MEM_W-1:0]         lease_mem [TABLE_ENTRIES];
    logic [MEM_W-1:0]         rd_data_reg;
    logic                     rd_empty_reg;
    logic [TABLE_ENTRIES-1:0] live_reg;

    // The sequencer never reads while a write is pending, so no forwarding.
    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            lease_mem[wr_addr] <= {wr_id, wr_stamp};
        end
        if (ctl.rd_en) begin
            rd_data_reg <= lease_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            live_reg     <= '0;
            rd_empty_reg <= 1'b1;
        end else begin
            if (ctl.wr_en) begin
                live_reg[wr_addr] <= ctl.wr_live;
            end
            if (ctl.rd_en) begin
                rd_empty_reg <= !live_reg[rd_addr];
            end
        end
    end

    assign rd_id    = rd_data_reg[MEM_W-1:STAMP_WIDTH];
    assign rd_stamp = rd_data_reg[STAMP_WIDTH-1:0];
    assign rd_empty = rd_empty_reg;

endmodule

// ----- rtl/core/lalt_scan.sv -----
// Request sequencer: scans the lease memory one entry per cycle, picks the
// matching, empty or oldest entry, writes it back and hands off the result.
// Depends on lalt_pkg.
module lalt_scan #(
    parameter int TABLE_ENTRIES = lalt_pkg::DEF_ENTRIES,
    parameter int STAMP_WIDTH   = lalt_pkg::DEF_STAMP_W,
    parameter int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // request side
    input  logic                      req_valid,
    output logic                      req_ready,
    input  logic [lalt_pkg::ID_W-1:0] req_id,
    // lease memory
    output lalt_pkg::mem_ctl_t        ctl,
    output logic [IDX_W-1:0]          rd_addr,
    output logic [IDX_W-1:0]          wr_addr,
    output logic [lalt_pkg::ID_W-1:0] wr_id,
    output logic [STAMP_WIDTH-1:0]    wr_stamp,
    input  logic [lalt_pkg::ID_W-1:0] rd_id,
    input  logic [STAMP_WIDTH-1:0]    rd_stamp,
    input  logic                      rd_empty,
    // result hand-off
    input  logic                      res_free,
    output logic                      res_load,
    output logic [lalt_pkg::ID_W-1:0] res_id,
    output logic [IDX_W-1:0]          res_idx
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_WRITE = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t                    state_reg, state_next;
    logic [lalt_pkg::ID_W-1:0] id_reg, id_next;
    logic [IDX_W-1:0]          rd_addr_reg, rd_addr_next;
    logic                      rd_active_reg, rd_active_next;
    logic                      cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]          cmp_idx_reg, cmp_idx_next;
    logic [STAMP_WIDTH-1:0]    best_stamp_reg, best_stamp_next;
    logic [IDX_W-1:0]          best_idx_reg, best_idx_next;
    logic [IDX_W-1:0]          pick_reg, pick_next;
    logic [STAMP_WIDTH-1:0]    counter_reg, counter_next;

    always_comb begin
        state_next      = state_reg;
        id_next         = id_reg;
        rd_addr_next    = rd_addr_reg;
        rd_active_next  = rd_active_reg;
        cmp_valid_next  = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        best_stamp_next = best_stamp_reg;
        best_idx_next   = best_idx_reg;
        pick_next       = pick_reg;
        counter_next    = counter_reg;
        ctl             = '0;
        res_load        = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (req_valid) begin
                    id_next         = req_id;
                    rd_addr_next    = '0;
                    rd_active_next  = 1'b1;
                    best_stamp_next = counter_reg;
                    best_idx_next   = '0;
                    state_next      = S_SCAN;
                end
            end
            S_SCAN: begin
                // Read one entry ahead of the compare.
                if (rd_active_reg) begin
                    ctl.rd_en      = 1'b1;
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = rd_addr_reg;
                    rd_addr_next   = rd_addr_reg + IDX_W'(1);
                    if (rd_addr_reg == LAST_IDX) begin
                        rd_active_next = 1'b0;
                    end
                end
                if (cmp_valid_reg) begin
                    if (rd_empty || rd_id == id_reg) begin
                        pick_next      = cmp_idx_reg;
                        rd_active_next = 1'b0;
                        cmp_valid_next = 1'b0;
                        state_next     = S_WRITE;
                    end else begin
                        if (rd_stamp < best_stamp_reg) begin
                            best_stamp_next = rd_stamp;
                            best_idx_next   = cmp_idx_reg;
                        end
                        if (cmp_idx_reg == LAST_IDX) begin
                            pick_next  = (rd_stamp < best_stamp_reg) ? cmp_idx_reg
                                                                     : best_idx_reg;
                            state_next = S_WRITE;
                        end
                    end
                end
            end
            S_WRITE: begin
                ctl.wr_en    = 1'b1;
                ctl.wr_live  = (id_reg != '0);
                counter_next = counter_reg + STAMP_WIDTH'(1);
                if (res_free) begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (res_free) begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            rd_active_reg <= 1'b0;
            cmp_valid_reg <= 1'b0;
            counter_reg   <= '0;
        end else begin
            state_reg     <= state_next;
            rd_active_reg <= rd_active_next;
            cmp_valid_reg <= cmp_valid_next;
            counter_reg   <= counter_next;
        end
    end

    always_ff @(posedge aclk) begin
        id_reg         <= id_next;
        rd_addr_reg    <= rd_addr_next;
        cmp_idx_reg    <= cmp_idx_next;
        best_stamp_reg <= best_stamp_next;
        best_idx_reg   <= best_idx_next;
        pick_reg       <= pick_next;
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rd_addr   = rd_addr_reg;
    assign wr_addr   = pick_reg;
    assign wr_id     = id_reg;
    assign wr_stamp  = counter_reg;
    assign res_id    = id_reg;
    assign res_idx   = pick_reg;

endmodule

// ----- rtl/core/lru_address_lease_table.sv -----
// LRU address lease table. A request is taken only while no scan is running.
// The scan reads the entries in order and ends early on a matching or empty
// entry, else after the last entry. The next request is taken the cycle after
// the result loads into the output register; a held result stalls it.
// Reset empties the table, zeroes the stamp counter and sets the base to 2.
module lru_address_lease_table #(
    parameter int TABLE_ENTRIES = lalt_pkg::DEF_ENTRIES,
    parameter int STAMP_WIDTH   = lalt_pkg::DEF_STAMP_W
) (
    input  logic        aclk,
    input  logic        aresetn,
    // request: [63:0] client_id
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,
    // result: [63:0] echoed_id, [71:64] assigned_address
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,
    // address base register
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int ID_W  = lalt_pkg::ID_W;
    localparam int ADDR_W = lalt_pkg::ADDR_W;

    lalt_pkg::mem_ctl_t     ctl;
    logic [IDX_W-1:0]       rd_addr, wr_addr, res_idx;
    logic [ID_W-1:0]        wr_id, rd_id, res_id;
    logic [STAMP_WIDTH-1:0] wr_stamp, rd_stamp;
    logic                   rd_empty, res_free, res_load;

    logic [ADDR_W-1:0]      base_reg;
    logic                   out_valid_reg;
    logic [ID_W-1:0]        out_id_reg;
    logic [ADDR_W-1:0]      out_addr_reg;

    lalt_store #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .STAMP_WIDTH   (STAMP_WIDTH),
        .IDX_W         (IDX_W)
    ) u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (ctl),
        .rd_addr  (rd_addr),
        .wr_addr  (wr_addr),
        .wr_id    (wr_id),
        .wr_stamp (wr_stamp),
        .rd_id    (rd_id),
        .rd_stamp (rd_stamp),
        .rd_empty (rd_empty)
    );

    lalt_scan #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .STAMP_WIDTH   (STAMP_WIDTH),
        .IDX_W         (IDX_W)
    ) u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req_id    (s_tdata),
        .ctl       (ctl),
        .rd_addr   (rd_addr),
        .wr_addr   (wr_addr),
        .wr_id     (wr_id),
        .wr_stamp  (wr_stamp),
        .rd_id     (rd_id),
        .rd_stamp  (rd_stamp),
        .rd_empty  (rd_empty),
        .res_free  (res_free),
        .res_load  (res_load),
        .res_id    (res_id),
        .res_idx   (res_idx)
    );

    assign res_free  = !out_valid_reg || m_tready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg      <= lalt_pkg::BASE_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                base_reg <= cfg_data;
            end
            if (res_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            out_id_reg   <= res_id;
            out_addr_reg <= ADDR_W'(res_idx) + base_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_addr_reg, out_id_reg};

endmodule

// ----- rtl/core/lalt_checker.sv -----
// Port-level checker for the LRU address lease table, bound to the top level.
// Depends on lru_address_lease_table_assert.svh.
`include "lru_address_lease_table_assert.svh"

module lalt_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata
);

    `LALT_ASSERT_NEXT(a_res_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")
    `LALT_ASSERT_NEXT(a_busy_next, aclk, aresetn, s_tvalid && s_tready, !s_tready, "request taken during a scan")
    `LALT_ASSERT_IMPL(a_busy_two, aclk, aresetn, s_tvalid && s_tready, ##2 !s_tready, "scan ended too early")
    `LALT_ASSERT_IMPL(a_res_idle, aclk, aresetn, $rose(m_tvalid), s_tready, "result issued while busy")

endmodule

bind lru_address_lease_table lalt_checker u_lalt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- verif/tb_top.sv -----
// Self-checking testbench for lru_address_lease_table: directed and random-id requests and
// idling on both stream sides, checked against a lease-table predictor in a scoreboard class.
// Depends on lalt_pkg and the lru_address_lease_table top level.
module tb_top;

    localparam int ENTRIES    = lalt_pkg::DEF_ENTRIES;
    localparam int STAMP_W    = lalt_pkg::DEF_STAMP_W;
    localparam int ID_W       = lalt_pkg::ID_W;
    localparam int ADDR_W     = lalt_pkg::ADDR_W;
    localparam int SCAN_CYCLES = ENTRIES + 4;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PRINT_LIMIT = 100;

    typedef struct {
        logic [ID_W-1:0]   id;
        logic [ADDR_W-1:0] addr;
    } lease_grant_t;

    class lease_scoreboard;
        logic [ID_W-1:0]    lease_id [ENTRIES];
        logic [STAMP_W-1:0] lease_stamp [ENTRIES];
        logic [STAMP_W-1:0] stamp_count;
        logic [ADDR_W-1:0]  address_base;
        lease_grant_t       pending_grants [$];
        int                 mismatches;

        function new();
            int k;
            for (k = 0; k < ENTRIES; k++) begin
                lease_id[k] = '0;
                lease_stamp[k] = '0;
            end
            stamp_count = '0;
            address_base = lalt_pkg::BASE_RESET;
            mismatches = 0;
        endfunction

        task report_mismatch(string msg);
            if (mismatches < PRINT_LIMIT)
                $display("MISMATCH: %s", msg);
            mismatches++;
        endtask

        // First matching or empty entry wins; otherwise the oldest stamp below the counter.
        function lease_grant_t predict_grant(logic [ID_W-1:0] id);
            logic [STAMP_W-1:0] best;
            logic [ADDR_W-1:0]  slot;
            int                 pick;
            int                 k;
            bit                 hit;
            lease_grant_t       g;
            best = stamp_count;
            pick = 0;
            hit = 0;
            for (k = 0; k < ENTRIES && !hit; k++) begin
                if (lease_id[k] == id || lease_id[k] == '0) begin
                    pick = k;
                    hit = 1;
                end else if (lease_stamp[k] < best) begin
                    best = lease_stamp[k];
                    pick = k;
                end
            end
            lease_id[pick] = id;
            lease_stamp[pick] = stamp_count;
            stamp_count = stamp_count + 1'b1;
            slot = pick[ADDR_W-1:0];
            g.id = id;
            g.addr = slot + address_base;
            return g;
        endfunction

        function void note_request(logic [ID_W-1:0] id);
            pending_grants.push_back(predict_grant(id));
        endfunction

        task check_result(logic [ID_W+ADDR_W-1:0] data);
            lease_grant_t g;
            if (pending_grants.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", data));
            end else begin
                g = pending_grants.pop_front();
                if (data[ID_W-1:0] !== g.id)
                    report_mismatch($sformatf("echoed_id %h, expected %h",
                                              data[ID_W-1:0], g.id));
                if (data[ID_W+ADDR_W-1:ID_W] !== g.addr)
                    report_mismatch($sformatf("assigned_address %0d, expected %0d for id %h",
                                              data[ID_W+ADDR_W-1:ID_W], g.addr, g.id));
            end
        endtask
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [63:0]            s_tdata;   // [63:0] client_id
    logic                   m_tvalid;
    logic                   m_tready;
    logic [71:0]            m_tdata;   // [63:0] echoed_id, [71:64] assigned_address
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [7:0]             cfg_data;

    lease_scoreboard        sb;
    bit                     stalls_on;
    int                     cycle_count;
    logic [ID_W-1:0]        id_pool [$];

    lru_address_lease_table #(
        .TABLE_ENTRIES (ENTRIES),
        .STAMP_WIDTH   (STAMP_W)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        stalls_on = 1'b1;
        cycle_count = 0;
        sb = new();
    end

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_request(s_tdata);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Result side: ready runs broken by stall bursts while stalls are enabled.
    initial begin
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (stalls_on && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(0, 30)) @(posedge aclk);
        end
    end

    // Called at a clock edge; returns at the edge where the request was taken.
    task send_request(logic [ID_W-1:0] id, int gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= id;
        do @(posedge aclk); while (!s_tready);
    endtask

    // The caller drops s_tvalid first. The queue is checked only once the last
    // taken request has been noted.
    task write_base(logic [7:0] value);
        @(posedge aclk);
        while (sb.pending_grants.size() != 0) @(posedge aclk);
        repeat (SCAN_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.address_base = value;
    endtask

    function int pick_gap();
        if (stalls_on && $urandom_range(0, 2) == 0)
            return $urandom_range(1, 19);
        return 0;
    endfunction

    function logic [ID_W-1:0] random_id();
        return {$urandom, $urandom};
    endfunction

    // A small pool of recurring clients gives matches; fresh ids force evictions.
    task run_random(int count, int pool_size);
        int              n;
        int              roll;
        logic [ID_W-1:0] id;
        id_pool.delete();
        for (n = 0; n < pool_size; n++)
            id_pool.push_back(random_id());
        if ($urandom_range(0, 1) == 1)
            id_pool.push_back({ID_W{1'b1}});
        for (n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 8)
                id = '0;
            else if (roll < 70)
                id = id_pool[$urandom_range(0, id_pool.size() - 1)];
            else
                id = random_id();
            send_request(id, pick_gap());
        end
        s_tvalid <= 1'b0;
    endtask

    initial begin
        wait (aresetn === 1'b1);
        @(posedge aclk);

        // Reset base; zero ids land on an empty entry that stays empty.
        send_request('0, 0);
        send_request('0, pick_gap());
        send_request({ID_W{1'b1}}, 0);
        send_request({ID_W{1'b1}}, pick_gap());
        send_request(64'h0000_0000_0000_0001, 0);
        send_request(64'h8000_0000_0000_0000, 0);
        send_request(64'h5555_5555_5555_5555, pick_gap());
        send_request(64'hAAAA_AAAA_AAAA_AAAA, 0);
        send_request(64'h0000_0000_FFFF_FFFF, 0);
        send_request(64'hFFFF_FFFF_0000_0000, pick_gap());
        send_request(64'h0123_4567_89AB_CDEF, 0);
        send_request(64'hFEDC_BA98_7654_3210, 0);
        send_request(64'h0000_0000_0000_0002, 0);
        // Table is full now: a zero id evicts the oldest entry and leaves it empty.
        send_request('0, 0);
        send_request(64'h0000_0000_0000_0003, 0);
        send_request(64'h0000_0000_0000_0004, pick_gap());
        send_request(64'h5555_5555_5555_5555, 0);
        s_tvalid <= 1'b0;

        // Address wraps past 255.
        write_base(8'd255);
        send_request(64'hFEDC_BA98_7654_3210, 0);
        send_request(64'h0000_0000_0000_0006, 0);
        send_request('0, 0);
        s_tvalid <= 1'b0;
        write_base(8'd250);
        send_request(64'h0000_0000_0000_0002, 0);
        send_request(64'h0000_0000_0000_0007, pick_gap());
        send_request({ID_W{1'b1}}, 0);
        s_tvalid <= 1'b0;

        write_base(8'd0);
        run_random(250, 8);
        write_base(8'd255);
        run_random(250, 14);
        write_base(8'($urandom_range(0, 255)));
        run_random(250, 4);
        write_base(8'd246);
        run_random(250, 20);
        write_base(8'($urandom_range(0, 255)));
        run_random(250, 11);

        stalls_on = 1'b0;
        write_base(8'($urandom_range(0, 255)));
        run_random(250, 10);

        while (sb.pending_grants.size() != 0) @(posedge aclk);
        repeat (SCAN_CYCLES * 2) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending_grants.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
    end

endmodule

// ----- lru_address_lease_table.f -----
+incdir+rtl/core
rtl/core/lalt_pkg.sv
rtl/core/lalt_store.sv
rtl/core/lalt_scan.sv
rtl/core/lru_address_lease_table.sv
rtl/core/lalt_checker.sv
verif/tb_top.sv
